### sv/eois_pkg.sv
// Package with shared constants and types for the even-odd interval set.
`default_nettype none
package eois_pkg;

    localparam int MAX_PAIRS_DEF  = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int OP_BITS        = 2;
    localparam int COUNT_OUT_BITS = 5;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_RECORD = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_TAIL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic rotate;
        logic write;
        logic commit;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/even_odd_interval_set.sv
// Top level of the even-odd interval set: control, cell row and fold unit.
//
// A request is taken when start is high and busy is low. op selects clear,
// record or covers query; span_start and span_end are signed fixed point.
// Every request gives exactly one result, shown for one cycle with done high:
// covered, list_empty, pair_count and overflow.
// Clear, query, unused op and an empty record show the result in the cycle
// after the request, and the next request can be taken in that same cycle.
// During a record over n stored intervals the fold unit visits one stored
// pair per cycle while the cell row rotates, then the trailing pair is
// appended and the work row is committed.
// A record whose result would exceed MAX_PAIRS intervals leaves the list as
// it was and reports overflow.
// Reset empties the list; stored bounds are not cleared. Results cannot be
// held off by the receiver, and busy stays high until the result is shown.
`default_nettype none
module even_odd_interval_set #(
    parameter int MAX_PAIRS  = eois_pkg::MAX_PAIRS_DEF,
    parameter int COORD_BITS = eois_pkg::COORD_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [eois_pkg::OP_BITS-1:0]      op,
    input  wire  signed [COORD_BITS-1:0]      span_start,
    input  wire  signed [COORD_BITS-1:0]      span_end,
    output logic                              done,
    output logic                              covered,
    output logic                              list_empty,
    output logic [eois_pkg::COUNT_OUT_BITS-1:0] pair_count,
    output logic                              overflow
);
    import eois_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int WCW = $clog2(MAX_PAIRS + 2);
    localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  step_reg, step_next;
    logic [WCW-1:0] wcount_reg, wcount_next;
    logic [W-1:0]   ys_reg, ys_next, ye_reg, ye_next;
    logic           seek_reg, seek_next, broken_reg, broken_next;
    logic           done_reg, done_next, covered_reg, covered_next;
    logic           overflow_reg, overflow_next;

    logic [W-1:0] key_s, key_e;
    logic [W-1:0] cell_lo [MAX_PAIRS];
    logic [W-1:0] cell_hi [MAX_PAIRS];
    logic         f_emit, f_seek, f_broken;
    logic [W-1:0] f_elo, f_ehi, f_clo, f_chi;
    logic         wr_en;
    logic [W-1:0] wr_lo, wr_hi;
    logic         rotate, commit;

    assign key_s = span_start ^ SIGN;
    assign key_e = span_end ^ SIGN;

    eois_fold #(.W(W)) u_fold (
        .seek        (seek_reg),
        .broken      (broken_reg),
        .ys          (ys_reg),
        .ye          (ye_reg),
        .lo          (cell_lo[0]),
        .hi          (cell_hi[0]),
        .emit        (f_emit),
        .emit_lo     (f_elo),
        .emit_hi     (f_ehi),
        .carry_lo    (f_clo),
        .carry_hi    (f_chi),
        .seek_next   (f_seek),
        .broken_next (f_broken)
    );

    for (genvar i = 0; i < MAX_PAIRS; i++)
    begin : g_cell
        cell_ctrl_t   ctrl;
        logic [W-1:0] nlo, nhi;
        logic         last;

        // The last occupied cell takes the head pair back, closing the ring.
        assign last = (i == MAX_PAIRS - 1) || (CW'(i + 1) == count_reg);
        assign nlo  = last ? cell_lo[0] : cell_lo[(i + 1) % MAX_PAIRS];
        assign nhi  = last ? cell_hi[0] : cell_hi[(i + 1) % MAX_PAIRS];
        assign ctrl.rotate = rotate;
        assign ctrl.write  = wr_en && (wcount_reg == WCW'(i));
        assign ctrl.commit = commit;

        eois_cell #(.W(W)) u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .rot_lo (nlo),
            .rot_hi (nhi),
            .wr_lo  (wr_lo),
            .wr_hi  (wr_hi),
            .lo     (cell_lo[i]),
            .hi     (cell_hi[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        wcount_next   = wcount_reg;
        ys_next       = ys_reg;
        ye_next       = ye_reg;
        seek_next     = seek_reg;
        broken_next   = broken_reg;
        done_next     = 1'b0;
        covered_next  = covered_reg;
        overflow_next = overflow_reg;
        wr_en         = 1'b0;
        wr_lo         = f_elo;
        wr_hi         = f_ehi;
        rotate        = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    covered_next  = 1'b0;
                    overflow_next = 1'b0;
                    ys_next       = key_s;
                    ye_next       = key_e;
                    seek_next     = 1'b1;
                    broken_next   = 1'b0;
                    wcount_next   = '0;
                    step_next     = '0;
                    done_next     = 1'b1;
                    case (op_t'(op))
                        OP_CLEAR:  count_next = '0;
                        OP_QUERY:  covered_next = (count_reg == CW'(1)) &&
                                                  (cell_lo[0] <= key_s) &&
                                                  (cell_hi[0] >= key_e);
                        OP_RECORD:
                        begin
                            if (key_s < key_e)
                            begin
                                done_next  = 1'b0;
                                state_next = (count_reg == '0) ? S_TAIL : S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK:
            begin
                rotate      = 1'b1;
                wr_en       = f_emit;
                wcount_next = wcount_reg + WCW'(f_emit);
                ys_next     = f_clo;
                ye_next     = f_chi;
                seek_next   = f_seek;
                broken_next = f_broken;
                step_next   = step_reg + CW'(1);
                if (step_reg + CW'(1) == count_reg)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                wr_en       = (ys_reg < ye_reg);
                wr_lo       = ys_reg;
                wr_hi       = ye_reg;
                wcount_next = wcount_reg + WCW'(ys_reg < ye_reg);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (wcount_reg > WCW'(MAX_PAIRS))
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    commit     = 1'b1;
                    count_next = CW'(wcount_reg);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            covered_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            covered_reg  <= covered_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        wcount_reg <= wcount_next;
        ys_reg     <= ys_next;
        ye_reg     <= ye_next;
        seek_reg   <= seek_next;
        broken_reg <= broken_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign covered    = covered_reg;
    assign overflow   = overflow_reg;
    assign list_empty = (count_reg == '0);
    assign pair_count = COUNT_OUT_BITS'(count_reg);

endmodule
`default_nettype wire

### sv/eois_cell.sv
// One interval cell: a stored pair that rotates through the row and a work pair.
`default_nettype none
module eois_cell #(
    parameter int W = eois_pkg::COORD_BITS_DEF
) (
    input  wire                     clk,
    input  eois_pkg::cell_ctrl_t    ctrl,
    input  wire  [W-1:0]            rot_lo,
    input  wire  [W-1:0]            rot_hi,
    input  wire  [W-1:0]            wr_lo,
    input  wire  [W-1:0]            wr_hi,
    output logic [W-1:0]            lo,
    output logic [W-1:0]            hi
);
    import eois_pkg::*;

    logic [W-1:0] lo_reg, hi_reg, wlo_reg, whi_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            lo_reg <= wlo_reg;
            hi_reg <= whi_reg;
        end
        else if (ctrl.rotate)
        begin
            lo_reg <= rot_lo;
            hi_reg <= rot_hi;
        end
        if (ctrl.write)
        begin
            wlo_reg <= wr_lo;
            whi_reg <= wr_hi;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule
`default_nettype wire

### sv/eois_fold.sv
// Folds one stored pair against the carried interval by symmetric difference.
`default_nettype none
module eois_fold #(
    parameter int W = eois_pkg::COORD_BITS_DEF
) (
    input  wire          seek,
    input  wire          broken,
    input  wire  [W-1:0] ys,
    input  wire  [W-1:0] ye,
    input  wire  [W-1:0] lo,
    input  wire  [W-1:0] hi,
    output logic         emit,
    output logic [W-1:0] emit_lo,
    output logic [W-1:0] emit_hi,
    output logic [W-1:0] carry_lo,
    output logic [W-1:0] carry_hi,
    output logic         seek_next,
    output logic         broken_next
);
    import eois_pkg::*;

    logic [W-1:0] a, b, c, d, b2, c2;

    always_comb
    begin
        a = (ys < lo) ? ys : lo;
        b = (ys < lo) ? lo : ys;
        c = (ye < hi) ? ye : hi;
        d = (ye < hi) ? hi : ye;
        b2 = (b > c) ? c : b;
        c2 = (b > c) ? b : c;
        emit        = 1'b0;
        emit_lo     = lo;
        emit_hi     = hi;
        carry_lo    = ys;
        carry_hi    = ye;
        seek_next   = 1'b0;
        broken_next = broken;
        if (broken)
        begin
            emit = 1'b1;
        end
        else if (seek && ys > hi)
        begin
            // Stored pair lies wholly below the new interval.
            emit      = 1'b1;
            seek_next = 1'b1;
        end
        else
        begin
            if (ye < lo)
            begin
                emit     = 1'b1;
                emit_lo  = ys;
                emit_hi  = ye;
                carry_lo = lo;
                carry_hi = hi;
            end
            else if (b == c)
            begin
                carry_lo = a;
                carry_hi = d;
            end
            else
            begin
                emit     = (a != b2);
                emit_lo  = a;
                emit_hi  = b2;
                carry_lo = c2;
                carry_hi = d;
            end
            broken_next = !(carry_lo < carry_hi);
        end
    end

endmodule
`default_nettype wire
